FILE: rtl/dsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive straightening mixer package
// Shared widths, register codes, reset values and the pipeline records.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int CountWidth  = 16;
  localparam int PowerWidth  = 8;
  localparam int GainWidth   = 10;
  localparam int CfgIdxWidth = 3;
  localparam int CfgWidth    = 16;
  localparam int DistWidth   = CountWidth + 1;
  localparam int ProdWidth   = CountWidth + GainWidth;
  localparam int CorrWidth   = ProdWidth - 8;
  localparam int SumWidth    = CorrWidth + 2;

  localparam logic signed [SumWidth-1:0] PowerMax = SumWidth'(127);
  localparam logic signed [SumWidth-1:0] PowerMin = -SumWidth'(127);

  localparam logic [1:0] ModeStraight    = 2'd0;
  localparam logic [1:0] ModeStrafeLeft  = 2'd1;
  localparam logic [1:0] ModeStrafeRight = 2'd2;

  localparam logic [CfgIdxWidth-1:0] RegDrivePower   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegTargetCounts = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegDriveMode    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegGainLeft     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegGainRight    = 3'd4;

  localparam logic [GainWidth-1:0] GainLeftReset  = 10'd123;
  localparam logic [GainWidth-1:0] GainRightReset = 10'd141;

  // Result of the measurement stage, consumed by the correction stage.
  typedef struct packed {
    logic                         done;
    logic [1:0]                   mode;
    logic signed [PowerWidth-1:0] power;
    logic [CountWidth-1:0]        err_mag;
    logic                         err_pos;
    logic                         err_neg;
    logic [GainWidth-1:0]         gain;
  } measure_t;

  typedef struct packed {
    logic                         done;
    logic signed [PowerWidth-1:0] left_front;
    logic signed [PowerWidth-1:0] left_back;
    logic signed [PowerWidth-1:0] right_front;
    logic signed [PowerWidth-1:0] right_back;
  } result_t;

  function automatic logic signed [PowerWidth-1:0] sat_power(
    input logic signed [SumWidth-1:0] v
  );
    logic signed [PowerWidth-1:0] res;
    if (v > PowerMax) begin
      res = PowerMax[PowerWidth-1:0];
    end else if (v < PowerMin) begin
      res = PowerMin[PowerWidth-1:0];
    end else begin
      res = v[PowerWidth-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/drive_straightening_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive straightening mixer
// Proportional side-to-side correction for a mecanum drive moving a set
// encoder distance.
// ----------------------------------------------------------------------------
// Each request carries the left and right encoder counts since the move
// began and yields one result of four wheel powers with a done flag. The
// block accepts one request per clock cycle unless held by a stalled output.
// It passes three register stages (input, measurement and correction), the
// first loaded at the accepting edge; the result is presented from the
// correction stage. Each stage refills as soon as its contents move on, so a
// stalled output only holds the input side once all three stages are full.
// The user must write registers through the configuration port only while
// no request is in flight; the block itself does not enforce this.
module drive_straightening_mixer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [dsm_pkg::CfgIdxWidth-1:0]     cfg_addr,
  input  wire logic [dsm_pkg::CfgWidth-1:0]        cfg_wdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // left_count [15:0], right_count [31:16]
  input  wire logic [2*dsm_pkg::CountWidth-1:0]    s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // left_front_power [7:0], left_back_power [15:8],
  // right_front_power [23:16], right_back_power [31:24]
  output logic [4*dsm_pkg::PowerWidth-1:0]         m_tdata,
  // move_done [0]
  output logic                                     m_tuser
);
  import dsm_pkg::*;

  logic signed [CfgWidth-1:0]   drive_power;
  logic [CountWidth-1:0]        target_counts;
  logic [1:0]                   drive_mode;
  logic [GainWidth-1:0]         gain_left;
  logic [GainWidth-1:0]         gain_right;

  logic                         in_valid;
  logic signed [CountWidth-1:0] left_count;
  logic signed [CountWidth-1:0] right_count;
  logic                         meas_ready;
  logic                         meas_valid;
  measure_t                     meas_data;
  logic                         corr_ready;
  result_t                      result;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_power   <= '0;
      target_counts <= '0;
      drive_mode    <= ModeStraight;
      gain_left     <= GainLeftReset;
      gain_right    <= GainRightReset;
    end else if (cfg_wen) begin
      case (cfg_addr)
        RegDrivePower:   drive_power   <= $signed(cfg_wdata);
        RegTargetCounts: target_counts <= cfg_wdata[CountWidth-1:0];
        RegDriveMode:    drive_mode    <= cfg_wdata[1:0];
        RegGainLeft:     gain_left     <= cfg_wdata[GainWidth-1:0];
        RegGainRight:    gain_right    <= cfg_wdata[GainWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !in_valid || meas_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      left_count  <= $signed(s_tdata[CountWidth-1:0]);
      right_count <= $signed(s_tdata[2*CountWidth-1:CountWidth]);
    end
  end

  dsm_measure u_measure (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (meas_ready),
    .left_count    (left_count),
    .right_count   (right_count),
    .drive_power   (drive_power),
    .target_counts (target_counts),
    .drive_mode    (drive_mode),
    .gain_left     (gain_left),
    .gain_right    (gain_right),
    .out_valid     (meas_valid),
    .out_ready     (corr_ready),
    .out_data      (meas_data)
  );

  dsm_correct u_correct (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (meas_valid),
    .in_ready  (corr_ready),
    .in_data   (meas_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  assign m_tdata = {result.right_back, result.right_front,
                    result.left_back, result.left_front};
  assign m_tuser = result.done;

endmodule
`default_nettype wire

FILE: rtl/dsm_measure.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive straightening mixer: measurement stage
// Distance test, count error, base power clamp and gain selection.
// ----------------------------------------------------------------------------
module dsm_measure (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [dsm_pkg::CountWidth-1:0] left_count,
  input  wire logic signed [dsm_pkg::CountWidth-1:0] right_count,
  input  wire logic signed [dsm_pkg::CfgWidth-1:0]   drive_power,
  input  wire logic [dsm_pkg::CountWidth-1:0]        target_counts,
  input  wire logic [1:0]                            drive_mode,
  input  wire logic [dsm_pkg::GainWidth-1:0]         gain_left,
  input  wire logic [dsm_pkg::GainWidth-1:0]         gain_right,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output dsm_pkg::measure_t                          out_data
);
  import dsm_pkg::*;

  logic signed [DistWidth-1:0]  sum;
  logic [DistWidth-1:0]         sum_mag;
  logic [CountWidth-1:0]        left_mag;
  logic [CountWidth-1:0]        right_mag;
  logic [DistWidth-1:0]         travel;
  logic [DistWidth-1:0]         twice_target;
  logic signed [DistWidth-1:0]  err;
  logic [DistWidth-1:0]         err_abs;
  logic                         straight;
  measure_t                     data_next;

  always_comb begin
    straight     = (drive_mode == ModeStraight);
    sum          = DistWidth'(left_count) + DistWidth'(right_count);
    sum_mag      = sum[DistWidth-1] ? DistWidth'(-sum) : DistWidth'(sum);
    left_mag     = left_count[CountWidth-1] ? CountWidth'(-left_count)
                                            : CountWidth'(left_count);
    right_mag    = right_count[CountWidth-1] ? CountWidth'(-right_count)
                                             : CountWidth'(right_count);
    travel       = straight ? sum_mag
                            : DistWidth'(left_mag) + DistWidth'(right_mag);
    twice_target = {target_counts, 1'b0};
    if (straight) begin
      err = DistWidth'(left_count) - DistWidth'(right_count);
    end else begin
      err = $signed({1'b0, left_mag}) - $signed({1'b0, right_mag});
    end
    err_abs = err[DistWidth-1] ? DistWidth'(-err) : DistWidth'(err);

    data_next.done    = (drive_mode != ModeStraight && drive_mode != ModeStrafeLeft
                         && drive_mode != ModeStrafeRight) || (travel >= twice_target);
    data_next.mode    = drive_mode;
    data_next.power   = sat_power(SumWidth'(drive_power));
    data_next.err_mag = err_abs[CountWidth-1:0];
    data_next.err_pos = !err[DistWidth-1] && (err != '0);
    data_next.err_neg = err[DistWidth-1];
    data_next.gain    = err[DistWidth-1] ? gain_right : gain_left;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dsm_correct.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive straightening mixer: correction stage
// Scales the error by the gain, subtracts it from the leading side's power (adds it in strafe-left mode),
// sets wheel signs and zeroes all powers once the move is done.
module dsm_correct (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dsm_pkg::measure_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dsm_pkg::result_t       out_data
);
  import dsm_pkg::*;

  logic [ProdWidth-1:0]         prod;
  logic [CorrWidth-1:0]         corr;
  logic signed [SumWidth-1:0]   base;
  logic signed [SumWidth-1:0]   adj;
  logic signed [PowerWidth-1:0] adj_sat;
  logic signed [PowerWidth-1:0] left_pwr;
  logic signed [PowerWidth-1:0] right_pwr;
  result_t                      data_next;

  always_comb begin
    prod = ProdWidth'(in_data.err_mag) * ProdWidth'(in_data.gain);
    corr = prod[ProdWidth-1:8];
    base = SumWidth'(in_data.power);
    if (in_data.mode == ModeStrafeLeft) begin
      adj = base + $signed({2'b00, corr});
    end else begin
      adj = base - $signed({2'b00, corr});
    end
    adj_sat   = sat_power(adj);
    left_pwr  = in_data.err_pos ? adj_sat : in_data.power;
    right_pwr = in_data.err_neg ? adj_sat : in_data.power;

    data_next.done = in_data.done;
    if (in_data.done) begin
      data_next.left_front  = '0;
      data_next.left_back   = '0;
      data_next.right_front = '0;
      data_next.right_back  = '0;
    end else begin
      case (in_data.mode)
        ModeStrafeLeft: begin
          data_next.left_front  = -left_pwr;
          data_next.left_back   = left_pwr;
          data_next.right_front = right_pwr;
          data_next.right_back  = -right_pwr;
        end
        ModeStrafeRight: begin
          data_next.left_front  = left_pwr;
          data_next.left_back   = -left_pwr;
          data_next.right_front = -right_pwr;
          data_next.right_back  = right_pwr;
        end
        default: begin
          data_next.left_front  = left_pwr;
          data_next.left_back   = left_pwr;
          data_next.right_front = right_pwr;
          data_next.right_back  = right_pwr;
        end
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire
